@@ rtl/cia_pkg.sv @@
// Shared types and constants for the checked integer ALU.
package cia_pkg;

    localparam int INT_BITS = 64;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_NEG = 3'd4;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_OVF  = 2'd1;
    localparam logic [1:0] ERR_DIV0 = 2'd2;

    localparam logic [INT_BITS-1:0] WSIGN = {1'b1, {(INT_BITS-1){1'b0}}};
    localparam logic [INT_BITS-1:0] WMAX  = {1'b0, {(INT_BITS-1){1'b1}}};

    // Work carried from cell to cell. One cell retires one bit of the
    // multiplier or one quotient bit of the divider.
    typedef struct packed {
        logic                  valid;
        logic [2:0]            func;
        logic                  neg;       // result sign flip for mul/div
        logic [1:0]            err;       // error already known at entry
        logic [INT_BITS-1:0]   quick;     // add/sub/neg result
        logic [INT_BITS-1:0]   ma;        // multiplicand magnitude or divisor
        logic [INT_BITS-1:0]   mb;        // multiplier bits / dividend bits
        logic [INT_BITS:0]     acc;       // product or partial remainder
        logic                  ovf;       // multiply overflow seen so far
    } cia_work_t;

endpackage

@@ rtl/cia_entry.sv @@
// Entry stage: operand decode, add/sub/negate and the error cases known up front.
module cia_entry (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2:0]                  func,
    input  logic [cia_pkg::INT_BITS-1:0] a,
    input  logic [cia_pkg::INT_BITS-1:0] b,
    output cia_pkg::cia_work_t          work
);
    import cia_pkg::*;

    cia_work_t work_reg;
    cia_work_t work_next;

    logic [INT_BITS-1:0] nb;
    logic [INT_BITS-1:0] addend;
    logic [INT_BITS-1:0] sum;
    logic                sum_ovf;
    logic [INT_BITS-1:0] ma_w;
    logic [INT_BITS-1:0] mb_w;

    assign nb     = INT_BITS'(0) - b;
    assign addend = (func == FUNC_SUB) ? nb : b;
    assign sum    = a + addend;
    assign sum_ovf = (a[INT_BITS-1] == addend[INT_BITS-1]) &&
                     (sum[INT_BITS-1] != a[INT_BITS-1]);
    assign ma_w   = a[INT_BITS-1] ? (INT_BITS'(0) - a) : a;
    assign mb_w   = b[INT_BITS-1] ? nb : b;

    always_comb
    begin
        work_next       = '0;
        work_next.valid = in_valid;
        work_next.func  = func;
        work_next.neg   = a[INT_BITS-1] ^ b[INT_BITS-1];
        case (func)
            FUNC_ADD:
            begin
                work_next.quick = sum;
                work_next.err   = sum_ovf ? ERR_OVF : ERR_NONE;
            end
            FUNC_SUB:
            begin
                work_next.quick = sum;
                work_next.err   = (b == WSIGN || sum_ovf) ? ERR_OVF : ERR_NONE;
            end
            FUNC_MUL:
            begin
                work_next.ma = ma_w;
                work_next.mb = mb_w;
            end
            FUNC_DIV:
            begin
                // Divisor in ma, dividend bits shift out of mb.
                work_next.ma = mb_w;
                work_next.mb = ma_w;
                if (b == '0)
                    work_next.err = ERR_DIV0;
                else if (a == WSIGN && b == {INT_BITS{1'b1}})
                    work_next.err = ERR_OVF;
            end
            FUNC_NEG:
            begin
                work_next.quick = INT_BITS'(0) - a;
            end
            default:
            begin
                work_next.quick = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            work_reg <= '0;
        else if (en)
            work_reg <= work_next;
    end

    assign work = work_reg;
endmodule

@@ rtl/cia_cell.sv @@
// One cell of the chain: one shift-add multiply step or one restoring divide step.
module cia_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  cia_pkg::cia_work_t work_in,
    output cia_pkg::cia_work_t work_out
);
    import cia_pkg::*;

    cia_work_t work_reg;
    cia_work_t work_next;

    logic [INT_BITS:0]   psum;
    logic [INT_BITS:0]   rem_sh;
    logic [INT_BITS:0]   rem_sub;

    // Multiply works from the top bit of mb down: acc = 2*acc + bit*ma.
    // Once acc exceeds WMAX the product can only grow, so flag and saturate.
    assign psum = {work_in.acc[INT_BITS-1:0], 1'b0} +
                  (work_in.mb[INT_BITS-1] ? {1'b0, work_in.ma} : '0);
    assign rem_sh  = {work_in.acc[INT_BITS-1:0], work_in.mb[INT_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, work_in.ma};

    always_comb
    begin
        work_next    = work_in;
        work_next.mb = {work_in.mb[INT_BITS-2:0], 1'b0};
        case (work_in.func)
            FUNC_MUL:
            begin
                if (work_in.ovf || work_in.acc[INT_BITS] ||
                    work_in.acc[INT_BITS-1] || psum > {1'b0, WMAX})
                begin
                    work_next.ovf = 1'b1;
                    work_next.acc = {1'b1, {INT_BITS{1'b0}}};
                end
                else
                    work_next.acc = psum;
            end
            FUNC_DIV:
            begin
                // acc holds the remainder; quotient bits enter quick from below.
                work_next.quick = {work_in.quick[INT_BITS-2:0], !rem_sub[INT_BITS]};
                work_next.acc   = rem_sub[INT_BITS] ? rem_sh : rem_sub;
            end
            default:
            begin
                work_next.mb = work_in.mb;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            work_reg <= '0;
        else if (en)
            work_reg <= work_next;
    end

    assign work_out = work_reg;
endmodule

@@ rtl/checked_integer_alu.sv @@
// Top level of the checked integer ALU: entry stage, cell chain and output register.
//
// Usage: an operation enters on the s_axis channel (func, operand_a, operand_b)
// and one result (result_value, error_code) leaves on the m_axis channel.
// Errors are 0 ok, 1 overflow, 2 division by zero; an errored result is zero.
// Every operation passes INT_BITS + 2 registers (66 for 64-bit words): one
// entry register, one per cell of the chain and one output register, with a
// combinational finishing step in front of the output register. Throughput is
// one transfer per cycle while the receiver does not stall. The depth is set by
// the cell chain, where each cell retires one multiplier bit or one quotient
// bit, so multiply and divide flow through it in order.
// The whole pipeline advances together; when the receiver stalls with a
// result held in the output register, every stage holds and s_axis_tready
// drops. Reset clears all valid flags; no result is pending afterward.
module checked_integer_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: func [2:0], operand_a [66:3], operand_b [130:67], zero pad [135:131]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: result_value [63:0], error_code [65:64], zero pad [71:66]
    output logic [71:0]  m_axis_tdata
);
    import cia_pkg::*;

    cia_work_t chain [0:INT_BITS];
    logic      en;

    logic                out_valid_reg;
    logic [INT_BITS-1:0] out_value_reg;
    logic [1:0]          out_err_reg;
    logic [INT_BITS-1:0] fin_value;
    logic [1:0]          fin_err;
    logic [INT_BITS-1:0] mag;
    cia_work_t           last;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    cia_entry u_entry (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .func     (s_axis_tdata[2:0]),
        .a        (s_axis_tdata[66:3]),
        .b        (s_axis_tdata[130:67]),
        .work     (chain[0])
    );

    for (genvar i = 0; i < INT_BITS; i++)
    begin : g_cell
        cia_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .work_in  (chain[i]),
            .work_out (chain[i+1])
        );
    end

    assign last = chain[INT_BITS];
    assign mag  = (last.func == FUNC_MUL) ? last.acc[INT_BITS-1:0] : last.quick;

    always_comb
    begin
        fin_err   = last.err;
        fin_value = '0;
        case (last.func)
            FUNC_MUL:
            begin
                if (last.ovf)
                    fin_err = ERR_OVF;
                else
                    fin_value = last.neg ? (INT_BITS'(0) - mag) : mag;
            end
            FUNC_DIV:
            begin
                fin_value = last.neg ? (INT_BITS'(0) - mag) : mag;
            end
            default:
            begin
                fin_value = last.quick;
            end
        endcase
        if (fin_err != ERR_NONE)
            fin_value = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg <= fin_value;
            out_err_reg   <= fin_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_err_reg, out_value_reg};

`ifndef SYNTHESIS
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output stall");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_errz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_err_reg != ERR_NONE |-> out_value_reg == '0)
        else $error("errored result not zero");
    a_errc: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_err_reg != 2'd3)
        else $error("bad error code");
`endif
endmodule
